### hw/rtl/rttk_pkg.sv
package rttk_pkg;

    localparam int TIME_W        = 32;
    localparam int SEQ_W         = 8;
    localparam int OP_W          = 2;
    localparam int AVG_DEPTH_DEF = 8;

    // operation codes carried in tuser
    localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
    localparam logic [OP_W-1:0] OP_PONG  = 2'd1;
    localparam logic [OP_W-1:0] OP_START = 2'd2;

    // configuration register indexes
    localparam logic REG_INTERVAL = 1'b0;
    localparam logic REG_ABORT    = 1'b1;

    localparam logic [TIME_W-1:0] INTERVAL_RST = 32'd1000;
    localparam logic [TIME_W-1:0] ABORT_RST    = 32'd5000;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [TIME_W-1:0] now_ms;
        logic [SEQ_W-1:0]  pong_seq;
    } item_t;

    typedef struct packed {
        logic [TIME_W-1:0] interval_ms;
        logic [TIME_W-1:0] abort_ms;
    } cfg_t;

    // per-item result flags that ride along with the running sum
    typedef struct packed {
        logic             send;
        logic [SEQ_W-1:0] seq;
        logic             matched;
        logic             mismatch;
    } info_t;

endpackage

### hw/rtl/rttk_ring.sv
module rttk_ring
    import rttk_pkg::*;
#(
    parameter int DEPTH = AVG_DEPTH_DEF,
    parameter int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [PW-1:0]     waddr,
    input  logic [TIME_W-1:0] wdata,
    input  logic [PW-1:0]     raddr,
    output logic [TIME_W-1:0] rdata
);

    logic [TIME_W-1:0] mem [DEPTH];
    logic [TIME_W-1:0] rd_reg;
    logic              byp_reg;
    logic [TIME_W-1:0] byp_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_reg       <= mem[raddr];
        byp_reg      <= we && (waddr == raddr);
        byp_data_reg <= wdata;
    end

    // write-first on a same-address collision
    assign rdata = byp_reg ? byp_data_reg : rd_reg;

endmodule

### hw/rtl/rttk_session.sv
module rttk_session
    import rttk_pkg::*;
#(
    parameter int AVG_DEPTH = AVG_DEPTH_DEF,
    parameter int SW        = TIME_W + $clog2(AVG_DEPTH)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  cfg_t          cfg,
    input  logic          in_valid,
    output logic          in_ready,
    input  item_t         in_item,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [SW-1:0] out_sum,
    output info_t         out_info
);

    localparam int PW = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
    localparam logic [PW-1:0] POS_LAST  = PW'(AVG_DEPTH - 1);
    localparam logic [SW-1:0] DEPTH_MUL = SW'(AVG_DEPTH);

    // input stage
    logic              in_vld_reg;
    item_t             item_reg;

    // result stage
    logic              st_vld_reg;
    logic [SW-1:0]     st_sum_reg;
    info_t             st_info_reg;

    // session state
    logic [SEQ_W-1:0]  seq_reg;
    logic [TIME_W-1:0] sent_reg;
    logic [TIME_W-1:0] pause_reg;
    logic              awaiting_reg;
    logic              no_pong_reg;
    logic [PW-1:0]     pos_reg;
    logic              wrapped_reg;
    logic [TIME_W-1:0] first_rtt_reg;
    logic [SW-1:0]     sum_reg;

    logic              st_ready;
    logic              adv;
    logic [TIME_W-1:0] el_sent;
    logic [TIME_W-1:0] el_pause;
    logic [SEQ_W-1:0]  seq_inc;
    logic              emit;
    logic              matched;
    logic              mismatch;
    logic [TIME_W-1:0] ring_rd;
    logic [TIME_W-1:0] old_rtt;
    logic [SW-1:0]     sum_next;
    logic              ring_we;
    logic [PW-1:0]     pos_next;

    assign st_ready  = !st_vld_reg || out_ready;
    assign adv       = in_vld_reg && st_ready;
    assign in_ready  = !in_vld_reg || st_ready;
    assign out_valid = st_vld_reg;
    assign out_sum   = st_sum_reg;
    assign out_info  = st_info_reg;

    assign el_sent  = item_reg.now_ms - sent_reg;
    assign el_pause = item_reg.now_ms - pause_reg;
    assign seq_inc  = seq_reg + SEQ_W'(1);

    always_comb
    begin
        emit     = 1'b0;
        matched  = 1'b0;
        mismatch = 1'b0;
        unique case (item_reg.op)
            OP_TICK:
            begin
                if (awaiting_reg)
                begin
                    emit = el_sent > cfg.abort_ms;
                end
                else
                begin
                    emit = el_pause > cfg.interval_ms;
                end
            end
            OP_PONG:
            begin
                mismatch = (item_reg.pong_seq != seq_reg);
                matched  = (item_reg.pong_seq == seq_reg);
            end
            OP_START:
            begin
                emit = 1'b1;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    // entries not yet overwritten since the first pong still hold its rtt
    assign old_rtt = wrapped_reg ? ring_rd : first_rtt_reg;

    always_comb
    begin
        if (no_pong_reg)
        begin
            sum_next = SW'(el_sent) * DEPTH_MUL;
        end
        else
        begin
            sum_next = sum_reg - SW'(old_rtt) + SW'(el_sent);
        end
    end

    assign ring_we  = adv && matched && !no_pong_reg;
    assign pos_next = !ring_we ? pos_reg :
                      (pos_reg == POS_LAST) ? '0 : pos_reg + PW'(1);

    rttk_ring #(
        .DEPTH (AVG_DEPTH),
        .PW    (PW)
    ) u_ring (
        .clk   (clk),
        .we    (ring_we),
        .waddr (pos_reg),
        .wdata (el_sent),
        .raddr (pos_next),
        .rdata (ring_rd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg   <= 1'b0;
            st_vld_reg   <= 1'b0;
            seq_reg      <= '0;
            sent_reg     <= '0;
            pause_reg    <= '0;
            awaiting_reg <= 1'b1;
            no_pong_reg  <= 1'b1;
            pos_reg      <= '0;
            wrapped_reg  <= 1'b0;
            sum_reg      <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                in_vld_reg <= in_valid;
            end
            if (st_ready)
            begin
                st_vld_reg <= in_vld_reg;
            end
            if (adv)
            begin
                if (emit)
                begin
                    seq_reg      <= seq_inc;
                    sent_reg     <= item_reg.now_ms;
                    awaiting_reg <= 1'b1;
                end
                if (matched)
                begin
                    pause_reg    <= item_reg.now_ms;
                    awaiting_reg <= 1'b0;
                    no_pong_reg  <= 1'b0;
                    sum_reg      <= sum_next;
                end
            end
            pos_reg <= pos_next;
            if (ring_we && (pos_reg == POS_LAST))
            begin
                wrapped_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
        if (adv && matched && no_pong_reg)
        begin
            first_rtt_reg <= el_sent;
        end
        if (adv)
        begin
            st_sum_reg           <= matched ? sum_next : sum_reg;
            st_info_reg.send     <= emit;
            st_info_reg.seq      <= emit ? seq_inc : '0;
            st_info_reg.matched  <= matched;
            st_info_reg.mismatch <= mismatch;
        end
    end

    a_pong_clears_wait: assert property (@(posedge clk) disable iff (!rst_n)
        adv && matched |=> !awaiting_reg)
        else $error("matching pong did not clear the pending ping");

    a_ping_sets_wait: assert property (@(posedge clk) disable iff (!rst_n)
        adv && emit |=> awaiting_reg && (sent_reg == $past(item_reg.now_ms)))
        else $error("ping did not record its send time");

    a_wrap_after_first: assert property (@(posedge clk) disable iff (!rst_n)
        wrapped_reg |-> !no_pong_reg)
        else $error("ring wrapped before the first pong");

endmodule

### hw/rtl/rttk_cdiv.sv
module rttk_cdiv
    import rttk_pkg::*;
#(
    parameter int WIDTH   = TIME_W + $clog2(AVG_DEPTH_DEF),
    parameter int DIVISOR = AVG_DEPTH_DEF
)
(
    input  logic [WIDTH-1:0]  in_dividend,
    output logic [TIME_W-1:0] out_quot
);

    localparam int SH = $clog2(DIVISOR);

    // divisor is a power of two and the sum never exceeds DIVISOR times the
    // largest rtt, so the quotient is the slice above the low SH bits
    assign out_quot = in_dividend[SH +: TIME_W];

endmodule

### hw/rtl/keepalive_ping_rtt_tracker_core.sv
// keepalive ping tracker with moving-average round-trip time
//
// s_axis carries one event per transfer: tuser holds the operation (tick,
// pong received, start/reconnect), tdata the current millisecond time and
// the sequence number of a received pong. m_axis returns exactly one result
// per event: whether a ping must go out now and its sequence number, the
// averaged rtt, and flags for an average change or a mismatched pong.
// cfg writes set the ping interval (index 0) and the abort timeout
// (index 1); cfg_ready is always high and writes are registered directly.
//
// throughput is one event per cycle, back to back, while m_axis is not
// stalled. the result of an event passes three registers on its way to
// m_axis: input register, session update into the result register, output
// register with the change flag. the average is floor(sum / AVG_DEPTH);
// AVG_DEPTH must be a power of two from 1 to 64 (the block does not check
// it), so the divide is a plain bit slice of the running sum.
//
// reset returns the session to its power-on state (ping pending, no pong
// seen yet, average zero) with no clearing pass. when m_axis stalls the
// three registers fill and then s_axis_tready drops; no result is lost.
module keepalive_ping_rtt_tracker_core
    import rttk_pkg::*;
#(
    parameter int AVG_DEPTH = AVG_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // now_ms[31:0], pong_seq[39:32]
    input  logic [1:0]  s_axis_tuser,   // op[1:0]

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // send_ping[0], ping_seq_out[8:1],
                                        // ping_changed[9], avg_rtt_ms[41:10],
                                        // seq_mismatch[42], zero fill[47:43]

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int SW = TIME_W + $clog2(AVG_DEPTH);

    // configuration registers
    logic [TIME_W-1:0] interval_reg;
    logic [TIME_W-1:0] abort_reg;
    cfg_t              cfg;

    // session to output stage
    item_t             in_item;
    logic              ses_valid;
    logic              ses_ready;
    logic [SW-1:0]     ses_sum;
    info_t             ses_info;
    logic [TIME_W-1:0] avg_quot;

    // output stage
    logic              out_vld_reg;
    logic              out_send_reg;
    logic [SEQ_W-1:0]  out_seq_reg;
    logic              out_changed_reg;
    logic [TIME_W-1:0] out_avg_reg;
    logic              out_mismatch_reg;
    logic [TIME_W-1:0] cur_avg_reg;
    logic              ses_xfer;

    assign cfg_ready       = 1'b1;
    assign cfg.interval_ms = interval_reg;
    assign cfg.abort_ms    = abort_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg <= INTERVAL_RST;
            abort_reg    <= ABORT_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_INTERVAL: interval_reg <= cfg_data;
                REG_ABORT:    abort_reg    <= cfg_data;
                default:      interval_reg <= interval_reg;
            endcase
        end
    end

    // unpack the incoming event
    assign in_item.op       = s_axis_tuser;
    assign in_item.now_ms   = s_axis_tdata[31:0];
    assign in_item.pong_seq = s_axis_tdata[39:32];

    // sequence counter, timers and the rtt ring; yields the running sum
    rttk_session #(
        .AVG_DEPTH (AVG_DEPTH),
        .SW        (SW)
    ) u_session (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_item   (in_item),
        .out_valid (ses_valid),
        .out_ready (ses_ready),
        .out_sum   (ses_sum),
        .out_info  (ses_info)
    );

    // sum / AVG_DEPTH
    rttk_cdiv #(
        .WIDTH   (SW),
        .DIVISOR (AVG_DEPTH)
    ) u_cdiv (
        .in_dividend (ses_sum),
        .out_quot    (avg_quot)
    );

    // output register; the reported average only moves on a matching pong,
    // in event order, so the change flag compares against the last one sent
    assign ses_ready = !out_vld_reg || m_axis_tready;
    assign ses_xfer  = ses_valid && ses_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
            cur_avg_reg <= '0;
        end
        else
        begin
            if (ses_ready)
            begin
                out_vld_reg <= ses_valid;
            end
            if (ses_xfer && ses_info.matched)
            begin
                cur_avg_reg <= avg_quot;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ses_xfer)
        begin
            out_send_reg     <= ses_info.send;
            out_seq_reg      <= ses_info.seq;
            out_mismatch_reg <= ses_info.mismatch;
            out_changed_reg  <= ses_info.matched && (avg_quot != cur_avg_reg);
            out_avg_reg      <= ses_info.matched ? avg_quot : cur_avg_reg;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {5'b0, out_mismatch_reg, out_avg_reg, out_changed_reg,
                            out_seq_reg, out_send_reg};

endmodule
